### rtl/core/mbf_pkg.sv
package mbf_pkg;

  localparam int NUM_LANES      = 4;
  localparam int COMP_W         = 8;
  localparam int SUM_W          = COMP_W + 1;
  localparam int TOT_W          = COMP_W + 2;
  localparam int LOG_W          = 4;
  localparam int NC_W           = 3;
  localparam int LEVEL_W        = 4;
  localparam int MAX_COMPONENTS = 4;

  localparam logic [LOG_W-1:0] WIDTH_LOG2_RESET  = 4'd8;
  localparam logic [LOG_W-1:0] HEIGHT_LOG2_RESET = 4'd8;
  localparam logic [NC_W-1:0]  NUM_COMP_RESET    = 3'd4;

  typedef enum logic [1:0] {
    REG_WIDTH_LOG2  = 2'd0,
    REG_HEIGHT_LOG2 = 2'd1,
    REG_NUM_COMP    = 2'd2
  } reg_idx_t;

  typedef logic [NUM_LANES-1:0][COMP_W-1:0] comp_vec_t;
  typedef logic [NUM_LANES-1:0][SUM_W-1:0]  sum_vec_t;

  typedef struct packed {
    logic [COMP_W-1:0] comp0;
    logic [COMP_W-1:0] comp1;
    logic [COMP_W-1:0] comp2;
    logic [COMP_W-1:0] comp3;
  } texel_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COMP_W-1:0]  out0;
    logic [COMP_W-1:0]  out1;
    logic [COMP_W-1:0]  out2;
    logic [COMP_W-1:0]  out3;
    logic               level_done;
    logic               last_of_run;
  } result_t;

  // broadcast from the register block to every level
  typedef struct packed {
    logic [LOG_W-1:0]   wl;
    logic [LOG_W-1:0]   hl;
    logic [LEVEL_W-1:0] levels;
    logic               restart;
  } cell_cfg_t;

  // what a level tells the level below it about its next texel
  typedef struct packed {
    logic at_last;
    logic will_complete;
  } cell_stat_t;

  localparam cell_stat_t END_STAT = '{at_last: 1'b1, will_complete: 1'b0};

endpackage

### rtl/core/mbf_stream_if.sv
interface mbf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/mbf_ram.sv
module mbf_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/mbf_level_cell.sv
module mbf_level_cell
  import mbf_pkg::*;
#(
  parameter int MAX_LOG2 = 12,
  parameter int K = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  cell_cfg_t  cfg,
  input  logic       load,
  input  comp_vec_t  load_data,
  input  logic       above_empty,
  input  logic       out_room,
  input  cell_stat_t next_stat,
  output logic       busy,
  output logic       can_load,
  output cell_stat_t stat,
  output logic       fwd,
  output comp_vec_t  fwd_data,
  output logic       emit,
  output result_t    emit_res
);

  localparam int PW    = MAX_LOG2 - K;
  localparam int DEPTH = (PW > 1) ? (1 << (PW - 1)) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEVEL_W-1:0] LVL    = LEVEL_W'(K);
  localparam logic [LEVEL_W-1:0] LVL_UP = LEVEL_W'(K + 1);

  logic            valid;
  logic            rd_done;
  comp_vec_t       v;
  logic [PW-1:0]   x;
  logic [PW-1:0]   y;
  sum_vec_t        pend;

  logic            dx, dy, active;
  logic [LOG_W-1:0] sh_x, sh_y;
  logic [PW-1:0]   x_mask, y_mask;
  logic            x_last, y_last;
  logic [PW-1:0]   x_next, y_next;
  logic            hold_x, hold_y, emits, fire;
  logic [AW-1:0]   row_addr;
  sum_vec_t        row_rd;
  sum_vec_t        pair;
  sum_vec_t        pend_next;
  comp_vec_t       vn;
  logic [TOT_W-1:0] tot [NUM_LANES];

  assign dx     = cfg.wl > LVL;
  assign dy     = cfg.hl > LVL;
  assign active = cfg.levels > LVL;

  assign sh_x   = cfg.wl - LVL;
  assign sh_y   = cfg.hl - LVL;
  assign x_mask = ~({PW{1'b1}} << sh_x);
  assign y_mask = ~({PW{1'b1}} << sh_y);
  assign x_last = !dx || (x == x_mask);
  assign y_last = !dy || (y == y_mask);

  assign x_next = x_last ? '0 : x + 1'b1;
  assign y_next = x_last ? (y_last ? '0 : y + 1'b1) : y;

  assign stat.at_last       = x_last && y_last;
  assign stat.will_complete = active && (!dx || x[0]) && (!dy || y[0]);

  // an even column parks the texel, an even row parks the pair sum
  assign hold_x = dx && !x[0];
  assign hold_y = dy && !y[0];
  assign emits  = active && !hold_x && !hold_y;
  assign fire   = valid && rd_done && (!emits || (above_empty && out_room));

  generate
    if (PW > 1) begin : g_addr
      assign row_addr = dx ? x[PW-1:1] : '0;
    end else begin : g_addr_one
      assign row_addr = '0;
    end
  endgenerate

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      pend_next[c] = {1'b0, v[c]};
      pair[c] = dx ? (pend[c] + {1'b0, v[c]}) : {v[c], 1'b0};
      tot[c]  = dy ? ({1'b0, row_rd[c]} + {1'b0, pair[c]}) : {pair[c], 1'b0};
      vn[c]   = tot[c][TOT_W-1:2];
    end
  end

  mbf_ram #(
    .WIDTH ($bits(sum_vec_t)),
    .DEPTH (DEPTH)
  ) u_row (
    .clk   (clk),
    .we    (fire && emits == 1'b0 && active && !hold_x && hold_y),
    .waddr (row_addr),
    .wdata (pair),
    .re    (valid && !rd_done),
    .raddr (row_addr),
    .rdata (row_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      rd_done <= 1'b0;
      x       <= '0;
      y       <= '0;
      pend    <= '0;
    end else begin
      valid   <= load || (valid && !fire);
      rd_done <= valid && !load && !fire;
      if (cfg.restart) begin
        x    <= '0;
        y    <= '0;
        pend <= '0;
      end else if (fire && active) begin
        x <= x_next;
        y <= y_next;
        if (hold_x) begin
          pend <= pend_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      v <= load_data;
    end
  end

  assign busy     = valid;
  assign can_load = !valid || fire;
  assign emit     = fire && emits;
  assign fwd      = emit && (cfg.levels > LVL_UP);
  assign fwd_data = vn;

  assign emit_res.level       = LVL_UP;
  assign emit_res.out0        = vn[0];
  assign emit_res.out1        = vn[1];
  assign emit_res.out2        = vn[2];
  assign emit_res.out3        = vn[3];
  assign emit_res.level_done  = next_stat.at_last;
  assign emit_res.last_of_run = !next_stat.will_complete;

endmodule

### rtl/core/mbf_out_fifo.sv
module mbf_out_fifo
  import mbf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    room,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  result_t    slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign room      = !count[1];
  assign out_valid = count != 2'd0;
  assign out_data  = slots[rptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

### rtl/core/mipmap_box_filter_chain_unit.sv
// Streaming mipmap builder with a 2x2 box filter.
// texel (sink): level-0 texels in raster order, one beat per texel.
// result (source): averaged texels of levels 1..L, lowest level first per
//   input beat; last_of_run marks the final result of that beat and
//   level_done the final texel of its level.
// APB port: width_log2 at 0x0, height_log2 at 0x4, num_components at 0x8.
//   A write there restarts the stream at texel (0,0); write only while idle.
// One level per chain stage, each with its own row buffer RAM. A texel waits
//   in a stage while the row buffer read completes, then combines. The first
//   stage takes a new texel only as the previous one combines. A texel that
//   completes a 2x2 block waits until every deeper stage has drained.
// Reset: registers go to 8/8/4 and all positions clear; row buffers need no
//   clearing pass since every entry is written before its contents are used.
// Stall: results go through a two-entry output queue; when full, stages with
//   a result hold; the first stage stops taking texels once it holds one.
module mipmap_box_filter_chain_unit
  import mbf_pkg::*;
#(
  parameter int MAX_SIZE_LOG2 = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  mbf_stream_if.sink   texel,
  mbf_stream_if.source result
);

  localparam logic [LOG_W-1:0] MAX_LOG = LOG_W'(MAX_SIZE_LOG2);
  localparam logic [NC_W-1:0]  MAX_NC  = NC_W'(MAX_COMPONENTS);

  logic [LOG_W-1:0] width_log2;
  logic [LOG_W-1:0] height_log2;
  logic [NC_W-1:0]  num_components;

  reg_idx_t         idx;
  logic             wr;
  logic             restart;
  logic [LOG_W-1:0] wl_eff, hl_eff;
  logic [NC_W-1:0]  nc_eff;
  cell_cfg_t        cfg;

  comp_vec_t        raw, masked;
  logic             accept;

  logic [MAX_SIZE_LOG2-1:0] busy;
  logic [MAX_SIZE_LOG2-1:0] above_empty;
  logic [MAX_SIZE_LOG2-1:0] can_load;
  logic [MAX_SIZE_LOG2-1:0] fwd;
  logic [MAX_SIZE_LOG2-1:0] emit;
  comp_vec_t                fwd_data [MAX_SIZE_LOG2];
  cell_stat_t               stat     [MAX_SIZE_LOG2];
  result_t                  emit_res [MAX_SIZE_LOG2];

  logic    push;
  result_t push_data;
  logic    room;

  // register port
  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  always_comb begin
    restart = 1'b0;
    prdata  = '0;
    case (idx)
      REG_WIDTH_LOG2: begin
        restart = wr;
        prdata  = 32'(width_log2);
      end
      REG_HEIGHT_LOG2: begin
        restart = wr;
        prdata  = 32'(height_log2);
      end
      REG_NUM_COMP: begin
        restart = wr;
        prdata  = 32'(num_components);
      end
      default: begin
        restart = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2     <= WIDTH_LOG2_RESET;
      height_log2    <= HEIGHT_LOG2_RESET;
      num_components <= NUM_COMP_RESET;
    end else if (wr) begin
      case (idx)
        REG_WIDTH_LOG2:  width_log2     <= pwdata[LOG_W-1:0];
        REG_HEIGHT_LOG2: height_log2    <= pwdata[LOG_W-1:0];
        REG_NUM_COMP:    num_components <= pwdata[NC_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the programmed values to what the chain supports
  assign wl_eff = (width_log2 > MAX_LOG) ? MAX_LOG : width_log2;
  assign hl_eff = (height_log2 > MAX_LOG) ? MAX_LOG : height_log2;
  assign nc_eff = (num_components == '0) ? NC_W'(1) :
                  (num_components > MAX_NC) ? MAX_NC : num_components;

  assign cfg.wl      = wl_eff;
  assign cfg.hl      = hl_eff;
  assign cfg.levels  = (wl_eff > hl_eff) ? wl_eff : hl_eff;
  assign cfg.restart = restart;

  // drop unused components at the door so every level sees zeros there
  assign raw = {texel.data.comp3, texel.data.comp2, texel.data.comp1, texel.data.comp0};

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      masked[c] = (NC_W'(c) < nc_eff) ? raw[c] : '0;
    end
  end

  assign texel.ready = can_load[0];
  assign accept      = texel.valid && texel.ready;

  always_comb begin
    for (int k = 0; k < MAX_SIZE_LOG2; k++) begin
      above_empty[k] = (busy >> (k + 1)) == '0;
    end
  end

  generate
    for (genvar k = 0; k < MAX_SIZE_LOG2; k++) begin : g_lvl
      logic       lvl_load;
      comp_vec_t  lvl_data;
      cell_stat_t lvl_next;

      if (k == 0) begin : g_head
        assign lvl_load = accept;
        assign lvl_data = masked;
      end else begin : g_body
        assign lvl_load = fwd[k-1];
        assign lvl_data = fwd_data[k-1];
      end

      if (k == MAX_SIZE_LOG2 - 1) begin : g_tail
        assign lvl_next = END_STAT;
      end else begin : g_inner
        assign lvl_next = stat[k+1];
      end

      mbf_level_cell #(
        .MAX_LOG2 (MAX_SIZE_LOG2),
        .K        (k)
      ) u_lvl (
        .clk         (clk),
        .rst         (rst),
        .cfg         (cfg),
        .load        (lvl_load),
        .load_data   (lvl_data),
        .above_empty (above_empty[k]),
        .out_room    (room),
        .next_stat   (lvl_next),
        .busy        (busy[k]),
        .can_load    (can_load[k]),
        .stat        (stat[k]),
        .fwd         (fwd[k]),
        .fwd_data    (fwd_data[k]),
        .emit        (emit[k]),
        .emit_res    (emit_res[k])
      );
    end
  endgenerate

  // at most one level emits in a cycle: the deepest busy one
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    for (int k = 0; k < MAX_SIZE_LOG2; k++) begin
      push      = push | emit[k];
      push_data = push_data | (emit[k] ? emit_res[k] : '0);
    end
  end

  mbf_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .room      (room),
    .out_valid (result.valid),
    .out_data  (result.data),
    .out_ready (result.ready)
  );

endmodule

### rtl/core/mbf_checker.sv
module mbf_checker
  import mbf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic        result_valid,
  input logic        result_ready,
  input result_t     result_data
);

  localparam logic [NC_W-1:0] MAX_NC = NC_W'(MAX_COMPONENTS);

  logic               out_acc;
  logic               run_open;
  logic [LEVEL_W-1:0] prev_level;
  logic [NC_W-1:0]    nc_shadow;
  logic [NC_W-1:0]    nc_eff;

  assign out_acc = result_valid && result_ready;
  assign nc_eff  = (nc_shadow == '0) ? NC_W'(1) :
                   (nc_shadow > MAX_NC) ? MAX_NC : nc_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open   <= 1'b0;
      prev_level <= '0;
      nc_shadow  <= NUM_COMP_RESET;
    end else begin
      if (out_acc) begin
        run_open   <= !result_data.last_of_run;
        prev_level <= result_data.level;
      end
      if (psel && penable && pwrite && reg_idx_t'(paddr[3:2]) == REG_NUM_COMP) begin
        nc_shadow <= pwdata[NC_W-1:0];
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result beat changed while stalled");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    out_acc && !run_open |-> result_data.level == LEVEL_W'(1))
    else $error("run did not start at level 1");

  a_run_step: assert property (@(posedge clk) disable iff (rst)
    out_acc && run_open |-> result_data.level == prev_level + LEVEL_W'(1))
    else $error("levels within a run not consecutive");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (nc_eff > NC_W'(1) || result_data.out1 == '0) &&
                (nc_eff > NC_W'(2) || result_data.out2 == '0) &&
                (nc_eff > NC_W'(3) || result_data.out3 == '0))
    else $error("unused component not zero");

endmodule

bind mipmap_box_filter_chain_unit mbf_checker u_mbf_checker (
  .clk          (clk),
  .rst          (rst),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);

### tb/tb_mipmap_box_filter_chain_unit.sv
module tb_mipmap_box_filter_chain_unit;
  import mbf_pkg::*;

  class mip_chain_model;
    localparam int MAX_LOG2 = 12;
    typedef logic [3:0][8:0] quad_sum_t;

    quad_sum_t row_sums[4096];
    quad_sum_t left_pair[MAX_LOG2];
    int unsigned col_pos[MAX_LOG2+1];
    int unsigned row_pos[MAX_LOG2+1];
    logic [LOG_W-1:0] wl_reg;
    logic [LOG_W-1:0] hl_reg;
    logic [NC_W-1:0] nc_reg;
    result_t owed_results[$];
    int mismatches;

    function new();
      foreach (row_sums[i]) row_sums[i] = '0;
      wl_reg = WIDTH_LOG2_RESET;
      hl_reg = HEIGHT_LOG2_RESET;
      nc_reg = NUM_COMP_RESET;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (left_pair[i]) left_pair[i] = '0;
      foreach (col_pos[i]) col_pos[i] = 0;
      foreach (row_pos[i]) row_pos[i] = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endfunction

    // a write to any of the three registers restarts the stream at texel (0,0)
    function void apply_reg(reg_idx_t r, logic [31:0] val);
      case (r)
        REG_WIDTH_LOG2:  wl_reg = val[LOG_W-1:0];
        REG_HEIGHT_LOG2: hl_reg = val[LOG_W-1:0];
        REG_NUM_COMP:    nc_reg = val[NC_W-1:0];
        default: return;
      endcase
      restart();
    endfunction

    function void note_texel(texel_t t);
      int unsigned wl, hl, levels, nc, x, y, wdt, hgt, base, idx, wn, hn;
      bit dx, dy;
      int n;
      logic [7:0] comp[4];
      logic [7:0] v[4];
      logic [8:0] pair[4];
      logic [9:0] tot[4];
      result_t r;
      wl = (wl_reg > MAX_LOG2) ? MAX_LOG2 : wl_reg;
      hl = (hl_reg > MAX_LOG2) ? MAX_LOG2 : hl_reg;
      levels = (wl > hl) ? wl : hl;
      nc = (nc_reg < 1) ? 1 : (nc_reg > MAX_COMPONENTS) ? MAX_COMPONENTS : nc_reg;
      comp = '{t.comp0, t.comp1, t.comp2, t.comp3};
      n = 0;
      for (int c = 0; c < 4; c++) v[c] = (c < nc) ? comp[c] : 8'd0;
      for (int unsigned k = 0; k < levels; k++) begin
        dx = wl > k;
        dy = hl > k;
        wdt = 1 << (dx ? wl - k : 0);
        hgt = 1 << (dy ? hl - k : 0);
        x = col_pos[k];
        y = row_pos[k];
        if (x + 1 >= wdt) begin
          col_pos[k] = 0;
          row_pos[k] = (y + 1 >= hgt) ? 0 : y + 1;
        end else begin
          col_pos[k] = x + 1;
        end
        if (dx) begin
          // hold the left texel until its right neighbor arrives
          if ((x & 1) == 0) begin
            for (int c = 0; c < 4; c++) left_pair[k][c] = {1'b0, v[c]};
            break;
          end
          for (int c = 0; c < 4; c++) pair[c] = left_pair[k][c] + v[c];
        end else begin
          for (int c = 0; c < 4; c++) pair[c] = {v[c], 1'b0};
        end
        if (dy) begin
          base = (k < wl) ? (1 << wl) - (1 << (wl - k)) : (1 << wl) - 1 + (k - wl);
          idx = (base + (dx ? (x >> 1) : 0)) & 4095;
          if ((y & 1) == 0) begin
            for (int c = 0; c < 4; c++) row_sums[idx][c] = pair[c];
            break;
          end
          for (int c = 0; c < 4; c++) tot[c] = row_sums[idx][c] + pair[c];
        end else begin
          for (int c = 0; c < 4; c++) tot[c] = {pair[c], 1'b0};
        end
        for (int c = 0; c < 4; c++) v[c] = tot[c][9:2];
        wn = 1 << ((wl > k + 1) ? wl - k - 1 : 0);
        hn = 1 << ((hl > k + 1) ? hl - k - 1 : 0);
        r.level = LEVEL_W'(k + 1);
        r.out0 = v[0];
        r.out1 = v[1];
        r.out2 = v[2];
        r.out3 = v[3];
        r.level_done = (col_pos[k+1] + 1 >= wn) && (row_pos[k+1] + 1 >= hn);
        r.last_of_run = 1'b0;
        owed_results.push_back(r);
        n++;
      end
      if (n > 0) owed_results[owed_results.size()-1].last_of_run = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t want;
      string diff;
      if (owed_results.size() == 0) begin
        report($sformatf("unexpected result level %0d", got.level));
        return;
      end
      want = owed_results.pop_front();
      diff = "";
      if (got.level !== want.level)
        diff = {diff, $sformatf(" level %0d/%0d", got.level, want.level)};
      if (got.out0 !== want.out0)
        diff = {diff, $sformatf(" out0 %h/%h", got.out0, want.out0)};
      if (got.out1 !== want.out1)
        diff = {diff, $sformatf(" out1 %h/%h", got.out1, want.out1)};
      if (got.out2 !== want.out2)
        diff = {diff, $sformatf(" out2 %h/%h", got.out2, want.out2)};
      if (got.out3 !== want.out3)
        diff = {diff, $sformatf(" out3 %h/%h", got.out3, want.out3)};
      if (got.level_done !== want.level_done)
        diff = {diff, $sformatf(" level_done %b/%b", got.level_done, want.level_done)};
      if (got.last_of_run !== want.last_of_run)
        diff = {diff, $sformatf(" last_of_run %b/%b", got.last_of_run, want.last_of_run)};
      if (diff != "") report({"result got/want:", diff});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mbf_stream_if #(.T(texel_t))  texel_if ();
  mbf_stream_if #(.T(result_t)) result_if ();

  mip_chain_model chain = new();

  bit idle_on = 1'b1;
  int hold_left = 0;
  int stall_left = 0;

  mipmap_box_filter_chain_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .texel   (texel_if),
    .result  (result_if)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1500000;
    $display("TB_ERROR");
    $finish;
  end

  // check output beats before noting input beats of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready) chain.check_result(result_if.data);
      if (texel_if.valid && texel_if.ready) chain.note_texel(texel_if.data);
    end
  end

  // receiver: long hold-off on request, else random stall bursts while idle_on is set
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result_if.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_if.ready = 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        result_if.ready = 1'b1;
      end
    end
  end

  task automatic apb_xfer(input bit wr, input reg_idx_t r, input logic [31:0] wdat,
                          output logic [31:0] rdat);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {r, 2'b00};
    pwdata = wdat;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdat = prdata;
    if (wr) chain.apply_reg(r, wdat);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(reg_idx_t r, int value);
    logic [31:0] mask;
    logic [31:0] rd;
    mask = (r == REG_NUM_COMP) ? 32'h7 : 32'hF;
    apb_xfer(1'b1, r, ($urandom & ~mask) | (value & mask), rd);
    apb_xfer(1'b0, r, $urandom, rd);
    if (rd !== (value & mask))
      chain.report($sformatf("register %s reads %h", r.name(), rd));
  endtask

  task automatic wait_drained();
    texel_if.valid = 1'b0;
    while (chain.owed_results.size() != 0) @(negedge clk);
  endtask

  // a texel with no result may still be in the chain: let it settle
  task automatic configure(int wl, int hl, int nc);
    wait_drained();
    repeat (30) @(negedge clk);
    write_reg(REG_WIDTH_LOG2, wl);
    write_reg(REG_HEIGHT_LOG2, hl);
    write_reg(REG_NUM_COMP, nc);
  endtask

  task automatic send_texel(texel_t t);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      texel_if.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    texel_if.data = t;
    texel_if.valid = 1'b1;
    do @(posedge clk); while (!texel_if.ready);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] rd;
    int wl, hl, nc, cnt, phase, rand_items;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    texel_if.valid = 1'b0;
    texel_if.data = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    apb_xfer(1'b0, REG_WIDTH_LOG2, '0, rd);
    if (rd !== 32'(WIDTH_LOG2_RESET)) chain.report($sformatf("width_log2 reset %h", rd));
    apb_xfer(1'b0, REG_HEIGHT_LOG2, '0, rd);
    if (rd !== 32'(HEIGHT_LOG2_RESET)) chain.report($sformatf("height_log2 reset %h", rd));
    apb_xfer(1'b0, REG_NUM_COMP, '0, rd);
    if (rd !== 32'(NUM_COMP_RESET)) chain.report($sformatf("num_components reset %h", rd));

    // one-texel texture: no results at all
    configure(0, 0, 4);
    send_texel('0);
    send_texel('1);
    // 2x2, two textures back to back
    configure(1, 1, 4);
    repeat (4) send_texel('1);
    send_texel(32'hFF00FF01);
    send_texel(32'h00FF00FE);
    send_texel(32'h01FE80FF);
    send_texel(32'hFF01FF00);
    // single row, zero components acts as one
    configure(2, 0, 0);
    send_texel(32'h01FFFFFF);
    send_texel(32'h02AAAAAA);
    send_texel(32'hFF555555);
    send_texel(32'hFE000000);
    // single column, component count above four
    configure(0, 1, 7);
    send_texel(32'h01020304);
    send_texel(32'hFFFFFFFF);
    // oversized width saturates; stream left partial, next write restarts it
    configure(15, 0, 3);
    repeat (4) send_texel($urandom);

    phase = 0;
    rand_items = 0;
    while (rand_items < 280) begin
      idle_on = rand_items < 230;
      nc = $urandom_range(0, 7);
      if (phase == 1) begin
        wl = 3;
        hl = 3;
        cnt = 64;
      end else if (phase == 2) begin
        wl = $urandom_range(12, 15);
        hl = $urandom_range(0, 1);
        cnt = 40;
      end else if (phase == 3) begin
        wl = 2;
        hl = 2;
        cnt = 32;
      end else if (phase == 5) begin
        wl = 0;
        hl = $urandom_range(12, 15);
        cnt = 40;
      end else begin
        wl = $urandom_range(0, 4);
        hl = $urandom_range(0, (6 - wl > 4) ? 4 : 6 - wl);
        cnt = (1 << (wl + hl)) * $urandom_range(1, 2);
        if ($urandom_range(0, 4) == 0) cnt = $urandom_range(1, cnt);
      end
      configure(wl, hl, nc);
      // hold off the receiver so the chain fills and stalls its input
      if (phase == 1) hold_left = 300;
      for (int i = 0; i < cnt; i++) begin
        if (phase == 3 && i == cnt / 2) wait_drained();
        send_texel($urandom);
      end
      rand_items += cnt;
      phase++;
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (chain.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
